// File: rtl/bytewise_hash64_mix_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bytewise hash core
// Concurrent assertion shorthands; define NO_ASSERTIONS to drop them all.
// ----------------------------------------------------------------------------
`ifndef BYTEWISE_HASH64_MIX_CORE_MACROS_SVH
`define BYTEWISE_HASH64_MIX_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define BHM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bhm assertion failed");

// Next-cycle implication.
`define BHM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bhm assertion failed");

`else

`define BHM_ASSERT_NOW(label, clk, rst, ante, cons)
`define BHM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/bhm_pkg.sv
// ----------------------------------------------------------------------------
// bhm_pkg
// Shared types, constants and mix-round tables of the bytewise hash core.
// ----------------------------------------------------------------------------
package bhm_pkg;

   localparam logic [63:0] GOLDEN_RATIO = 64'h9e3779b97f4a7c13;
   localparam int BLOCK_BYTES = 24;
   localparam int LANE_BITS   = 64;
   localparam int BLOCK_BITS  = BLOCK_BYTES * 8;
   localparam int MIX_LINES   = 12;
   localparam int QUEUE_DEPTH = 2;

   // Word updated by one line of the mix.
   localparam logic [1:0] TGT_A = 2'd0;
   localparam logic [1:0] TGT_B = 2'd1;
   localparam logic [1:0] TGT_C = 2'd2;

   // One unit of work for the mixer: a full block, a key end, or both.
   typedef struct packed {
      logic                  first;  // first entry of a key: start from the seed
      logic                  full;   // lanes hold a complete block
      logic                  fin;    // key ends with this entry
      logic [63:0]           seed;
      logic [63:0]           len;
      logic [BLOCK_BITS-1:0] lanes;
   } blk_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic [5:0] mix_shift(input logic [3:0] line);
      logic [5:0] sh;
      case (line)
         4'd0:    sh = 6'd43;
         4'd1:    sh = 6'd9;
         4'd2:    sh = 6'd8;
         4'd3:    sh = 6'd38;
         4'd4:    sh = 6'd23;
         4'd5:    sh = 6'd5;
         4'd6:    sh = 6'd35;
         4'd7:    sh = 6'd49;
         4'd8:    sh = 6'd11;
         4'd9:    sh = 6'd12;
         4'd10:   sh = 6'd18;
         4'd11:   sh = 6'd22;
         default: sh = 6'd0;
      endcase
      return sh;
   endfunction

   function automatic logic [1:0] mix_target(input logic [3:0] line);
      logic [1:0] tgt;
      case (line)
         4'd0, 4'd3, 4'd6, 4'd9:  tgt = TGT_A;
         4'd1, 4'd4, 4'd7, 4'd10: tgt = TGT_B;
         default:                 tgt = TGT_C;
      endcase
      return tgt;
   endfunction

endpackage

// File: rtl/bhm_front.sv
// ----------------------------------------------------------------------------
// bhm_front
// Packs key bytes into block lanes, counts length and queues block work.
// ----------------------------------------------------------------------------
module bhm_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,
   input  logic                   req_tlast,
   input  logic                   req_tuser,
   input  logic                   csr_we,
   input  logic [63:0]            csr_wdata,
   input  bhm_pkg::q_status_type  q_status,
   output logic                   push,
   output bhm_pkg::blk_entry_type push_data
);

   logic [bhm_pkg::BLOCK_BITS-1:0] lanes_ff, lanes_in, lanes_new;
   logic [4:0]  bib_ff, bib_in;
   logic [63:0] len_ff, len_in, len_new;
   logic [63:0] seed_ff, seed_in;
   logic [63:0] key_seed_ff, key_seed_in;
   logic        first_ff, first_in;
   logic        accept, blk_done, fin;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      lanes_new = lanes_ff;
      lanes_new[{bib_ff, 3'b000} +: 8] = req_tdata;
   end

   assign len_new  = len_ff + 64'd1;
   assign blk_done = !req_tuser && (bib_ff == 5'(bhm_pkg::BLOCK_BYTES - 1));
   assign fin      = req_tuser || req_tlast;
   assign push     = accept && (blk_done || fin);

   always_comb begin
      push_data.first = first_ff;
      push_data.full  = blk_done;
      push_data.fin   = fin;
      push_data.seed  = key_seed_ff;
      push_data.len   = req_tuser ? len_ff : len_new;
      push_data.lanes = req_tuser ? lanes_ff : lanes_new;
   end

   always_comb begin
      lanes_in    = lanes_ff;
      bib_in      = bib_ff;
      len_in      = len_ff;
      first_in    = first_ff;
      seed_in     = csr_we ? csr_wdata : seed_ff;
      key_seed_in = key_seed_ff;
      if (csr_we && (len_ff == 64'd0) && (bib_ff == 5'd0)) begin
         key_seed_in = csr_wdata;
      end
      if (accept) begin
         if (fin) begin
            lanes_in    = '0;
            bib_in      = 5'd0;
            len_in      = 64'd0;
            first_in    = 1'b1;
            key_seed_in = seed_in;
         end else if (blk_done) begin
            lanes_in = '0;
            bib_in   = 5'd0;
            len_in   = len_new;
            first_in = 1'b0;
         end else begin
            lanes_in = lanes_new;
            bib_in   = bib_ff + 5'd1;
            len_in   = len_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lanes_ff    <= '0;
         bib_ff      <= 5'd0;
         len_ff      <= 64'd0;
         first_ff    <= 1'b1;
         seed_ff     <= 64'd0;
         key_seed_ff <= 64'd0;
      end else begin
         lanes_ff    <= lanes_in;
         bib_ff      <= bib_in;
         len_ff      <= len_in;
         first_ff    <= first_in;
         seed_ff     <= seed_in;
         key_seed_ff <= key_seed_in;
      end
   end

endmodule

// File: rtl/bhm_queue.sv
// ----------------------------------------------------------------------------
// bhm_queue
// Small first-in first-out queue of block work between packer and mixer.
// ----------------------------------------------------------------------------
module bhm_queue #(
   parameter int Depth = bhm_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  bhm_pkg::blk_entry_type push_data,
   input  logic                   pop,
   output bhm_pkg::blk_entry_type head,
   output bhm_pkg::q_status_type  status
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   bhm_pkg::blk_entry_type slot_ff [Depth];
   logic [PtrW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CntW-1:0] cnt_ff, cnt_in;

   assign status.full  = (cnt_ff == CntW'(Depth));
   assign status.empty = (cnt_ff == '0);
   assign head         = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PtrW'(Depth - 1)) ? '0 : wr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PtrW'(Depth - 1)) ? '0 : rd_ff + PtrW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CntW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: rtl/bhm_back.sv
// ----------------------------------------------------------------------------
// bhm_back
// Mixer: adds lanes into a, b, c; mixes one line per cycle unless stalled.
// ----------------------------------------------------------------------------
`include "bytewise_hash64_mix_core_macros.svh"

module bhm_back (
   input  logic                   clock,
   input  logic                   reset,
   input  bhm_pkg::blk_entry_type head,
   input  logic                   head_valid,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [63:0]            rsp_tdata
);

   logic [63:0] a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic [63:0] base_a, base_b, base_c;
   logic [63:0] l0, l1, l2;
   logic [3:0]  step_ff, step_in, line;
   logic        pass_ff, pass_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff, rsp_data_in;
   logic [5:0]  sh;
   logic [1:0]  tgt;
   logic        last_line, last_pass, out_free, emit, advance;

   assign l0 = head.lanes[63:0];
   assign l1 = head.lanes[127:64];
   assign l2 = head.lanes[191:128];

   // The first entry of a key starts from the seed and the golden ratio.
   assign base_a = (head.first && !pass_ff) ? head.seed : a_ff;
   assign base_b = (head.first && !pass_ff) ? head.seed : b_ff;
   assign base_c = (head.first && !pass_ff) ? bhm_pkg::GOLDEN_RATIO : c_ff;

   assign line      = step_ff - 4'd1;
   assign sh        = bhm_pkg::mix_shift(line);
   assign tgt       = bhm_pkg::mix_target(line);
   assign last_line = (step_ff == 4'(bhm_pkg::MIX_LINES));
   assign last_pass = pass_ff || !(head.full && head.fin);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign emit      = head_valid && last_line && last_pass && head.fin;
   assign advance   = head_valid && !(emit && !out_free);
   assign pop       = advance && last_line && last_pass;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      c_in    = c_ff;
      step_in = step_ff;
      pass_in = pass_ff;
      if (advance) begin
         if (step_ff == 4'd0) begin
            if (pass_ff) begin
               // Block ended the key: only the length remains to add.
               c_in = c_ff + head.len;
            end else if (head.full) begin
               a_in = base_a + l0;
               b_in = base_b + l1;
               c_in = base_c + l2;
            end else begin
               a_in = base_a + l0;
               b_in = base_b + l1;
               c_in = base_c + head.len + {l2[55:0], 8'h00};
            end
         end else begin
            case (tgt)
               bhm_pkg::TGT_A: a_in = (a_ff - b_ff - c_ff) ^ (c_ff >> sh);
               bhm_pkg::TGT_B: b_in = (b_ff - c_ff - a_ff) ^ (a_ff << sh);
               bhm_pkg::TGT_C: c_in = (c_ff - a_ff - b_ff) ^ (b_ff >> sh);
               default: begin
                  a_in = a_ff;
               end
            endcase
         end
         if (last_line) begin
            step_in = 4'd0;
            pass_in = !last_pass;
         end else begin
            step_in = step_ff + 4'd1;
         end
      end
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (emit && advance) begin
         rsp_data_in  = c_in;
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      c_ff        <= c_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 4'd0;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `BHM_ASSERT_NOW(a_step_range, clock, reset, 1'b1, step_ff <= 4'(bhm_pkg::MIX_LINES))
   `BHM_ASSERT_NOW(a_pass_kind, clock, reset, pass_ff, head_valid && head.full && head.fin)
   `BHM_ASSERT_NEXT(a_pop_restart, clock, reset, pop, step_ff == 4'd0 && !pass_ff)
   `BHM_ASSERT_NEXT(a_emit_shown, clock, reset, emit && advance, rsp_valid_ff)

endmodule

// File: rtl/bytewise_hash64_mix_core.sv
// ----------------------------------------------------------------------------
// bytewise_hash64_mix_core
// 64-bit lookup8 hash of a key that streams in one byte per item.
// ----------------------------------------------------------------------------
// Usage: each req item carries one key byte in req_tdata; req_tlast marks the
// final byte, and req_tuser ends the key without a byte (a zero-length key
// when nothing is in progress). At each key end one rsp item carries the hash.
// The seed register (csr_we, csr_wdata) is to be written only while the core
// is idle; the core itself does not enforce this. Bytes are taken at one per
// cycle while the queue has room: the packer fills three 64-bit lanes and,
// every 24 bytes or at a key end, queues a work entry for the mixer. The mixer
// first adds the lanes in and then runs the twelve mix lines; an entry whose key
// ends exactly on a block boundary takes a second pass to add the length. Long
// keys stream at one byte per cycle; a stream of short keys is set by the mixer.
// Reset clears the seed to zero and empties the queue and output register.
// When the receiver stalls, the hash waits in the output register, the mixer
// holds on its last line and the queue fills before req_tready drops.
// ----------------------------------------------------------------------------
module bytewise_hash64_mix_core #(
   parameter int QueueDepth = bhm_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // Input items.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] key_byte
   input  logic        req_tlast,   // last_byte
   input  logic        req_tuser,   // [0] empty_key
   // Result items.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] hash_value
   // Seed register.
   input  logic        csr_we,
   input  logic [63:0] csr_wdata
);

   bhm_pkg::blk_entry_type push_data, head;
   bhm_pkg::q_status_type  q_status;
   logic                   push, pop;

   // Front end: byte packing, length count and seed bookkeeping.
   bhm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .q_status   (q_status),
      .push       (push),
      .push_data  (push_data)
   );

   // Work queue that lets packing run ahead of mixing.
   bhm_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   // Back end: lane add-in, the twelve-line mix and the output register.
   bhm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (!q_status.empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
